// File: rtl/urlpd_pkg.sv
// urlpd_pkg: shared types, character codes and hex helpers for the url percent decoder
// no dependencies; imported by the front, queue, back and top level
`default_nettype none

package urlpd_pkg;

    // escape window: '%' plus up to four pending bytes, plus the incoming byte
    localparam int WIN_DEPTH = 6;
    localparam int CNT_W     = 3;

    localparam logic [7:0] CH_PCT = 8'h25;
    localparam logic [7:0] CH_U   = 8'h75;

    // decode_mode codes; code 3 enables both forms
    localparam logic [1:0] MODE_HEX  = 2'd0;
    localparam logic [1:0] MODE_UNI  = 2'd1;
    localparam logic [1:0] MODE_BOTH = 2'd2;

    typedef enum logic [1:0] {
        CMD_LIT,
        CMD_HEX,
        CMD_UNI
    } cmd_kind_t;

    // one queued command: a literal run or a decoded escape
    typedef struct packed {
        cmd_kind_t                    kind;
        logic [WIN_DEPTH-1:0][7:0]    data;
        logic [CNT_W-1:0]             count;
        logic                         last;
    } cmd_t;

    function automatic logic is_hex(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h46)) ||
               ((c >= 8'h61) && (c <= 8'h66));
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] t;
        if ((c >= 8'h30) && (c <= 8'h39))
        begin
            t = c - 8'h30;
        end
        else if ((c >= 8'h41) && (c <= 8'h46))
        begin
            t = c - 8'h37;
        end
        else if ((c >= 8'h61) && (c <= 8'h66))
        begin
            t = c - 8'h57;
        end
        else
        begin
            t = 8'h00;
        end
        return t[3:0];
    endfunction

    function automatic logic [7:0] hex_pair(input logic [7:0] hi, input logic [7:0] lo);
        return {hex_val(hi), hex_val(lo)};
    endfunction

endpackage

`default_nettype wire

// File: rtl/urlpd_front.sv
// urlpd_front: accepts input words, tracks the pending escape window, classifies each word
// depends on urlpd_pkg; feeds commands to urlpd_queue
`default_nettype none

module urlpd_front
    import urlpd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire logic [7:0]  in_byte,
    input  wire logic        in_last,
    input  wire logic [1:0]  decode_mode,
    output logic             cmd_valid,
    output cmd_t             cmd
);

    logic [CNT_W-1:0] wcnt_reg, wcnt_next;
    logic [7:0]       win_reg [WIN_DEPTH-1];

    logic             allow_hex, allow_u;
    logic             b_hex, head_u, head_h;
    logic             ok_next, complete, start;
    logic [CNT_W-1:0] lit_count;
    logic             win_we;
    logic [CNT_W-1:0] win_idx;

    always_comb
    begin
        allow_hex = (decode_mode != MODE_UNI);
        allow_u   = (decode_mode != MODE_HEX);
        b_hex     = is_hex(in_byte);

        // head kind is re-evaluated under the current mode
        head_u = (wcnt_reg >= 3'd2) && allow_u && (win_reg[1] == CH_U);
        head_h = (wcnt_reg >= 3'd2) && !head_u && allow_hex && is_hex(win_reg[1]);

        ok_next = ((wcnt_reg == 3'd1) &&
                   ((allow_u && (in_byte == CH_U)) || (allow_hex && b_hex))) ||
                  ((head_u || head_h) && b_hex);
        complete = ok_next && (head_h || (head_u && (wcnt_reg == 3'd5)));
        start    = !ok_next && (in_byte == CH_PCT) && !in_last;

        lit_count = (!ok_next && start) ? wcnt_reg : (wcnt_reg + 3'd1);

        for (int i = 0; i < WIN_DEPTH; i++)
        begin
            cmd.data[i] = in_byte;
        end
        for (int i = 0; i < WIN_DEPTH - 1; i++)
        begin
            if (3'(i) < wcnt_reg)
            begin
                cmd.data[i] = win_reg[i];
            end
        end

        cmd.last = in_last;
        if (complete)
        begin
            cmd.kind  = head_h ? CMD_HEX : CMD_UNI;
            cmd.count = head_h ? 3'd1 : 3'd2;
        end
        else
        begin
            cmd.kind  = CMD_LIT;
            cmd.count = lit_count;
        end

        cmd_valid = accept &&
                    (complete || (ok_next ? in_last : (lit_count != 3'd0)));

        wcnt_next = wcnt_reg;
        win_we    = 1'b0;
        win_idx   = wcnt_reg;
        if (accept)
        begin
            if (complete)
            begin
                wcnt_next = 3'd0;
            end
            else if (ok_next)
            begin
                if (in_last)
                begin
                    wcnt_next = 3'd0;
                end
                else
                begin
                    wcnt_next = wcnt_reg + 3'd1;
                    win_we    = 1'b1;
                end
            end
            else if (start)
            begin
                wcnt_next = 3'd1;
                win_we    = 1'b1;
                win_idx   = 3'd0;
            end
            else
            begin
                wcnt_next = 3'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wcnt_reg <= '0;
        end
        else
        begin
            wcnt_reg <= wcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (win_we)
        begin
            win_reg[win_idx] <= in_byte;
        end
    end

endmodule

`default_nettype wire

// File: rtl/urlpd_queue.sv
// urlpd_queue: short command queue between the front and the back
// depends on urlpd_pkg for cmd_t
`default_nettype none

module urlpd_queue
    import urlpd_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  wr_en,
    input  wire cmd_t  wr_cmd,
    output logic       full,
    input  wire logic  rd_en,
    output cmd_t       rd_cmd,
    output logic       rd_valid
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);

    cmd_t              mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;

    always_comb
    begin
        full     = (fill_reg == FILL_W'(DEPTH));
        rd_valid = (fill_reg != '0);
        rd_cmd   = mem_reg[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (!wr_en && rd_en)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

`default_nettype wire

// File: rtl/urlpd_back.sv
// urlpd_back: takes commands from the queue and emits one output word per clock while pop is high and a command is held
// depends on urlpd_pkg for cmd_t and hex_pair
`default_nettype none

module urlpd_back
    import urlpd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cmd_t        q_cmd,
    input  wire logic        q_valid,
    output logic             q_pop,
    input  wire logic        pop,
    output logic             empty,
    output logic [7:0]       out_byte,
    output logic             out_last
);

    cmd_t             cmd_reg, cmd_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             busy_reg, busy_next;
    logic             end_of_cmd, take, load;

    always_comb
    begin
        end_of_cmd = (idx_reg == (cmd_reg.count - 3'd1));
        take       = busy_reg && pop;
        load       = (!busy_reg || (take && end_of_cmd)) && q_valid;
        q_pop      = load;

        empty    = !busy_reg;
        out_last = cmd_reg.last && end_of_cmd;

        unique case (cmd_reg.kind)
            CMD_LIT: out_byte = cmd_reg.data[idx_reg];
            CMD_HEX: out_byte = hex_pair(cmd_reg.data[1], cmd_reg.data[2]);
            CMD_UNI: out_byte = (idx_reg == 3'd0) ?
                                hex_pair(cmd_reg.data[2], cmd_reg.data[3]) :
                                hex_pair(cmd_reg.data[4], cmd_reg.data[5]);
            default: out_byte = cmd_reg.data[idx_reg];
        endcase

        cmd_next  = cmd_reg;
        idx_next  = idx_reg;
        busy_next = busy_reg;
        if (load)
        begin
            cmd_next  = q_cmd;
            idx_next  = '0;
            busy_next = 1'b1;
        end
        else if (take)
        begin
            if (end_of_cmd)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

endmodule

`default_nettype wire

// File: rtl/url_percent_decoder.sv
// url_percent_decoder: top level of the streaming url percent decoder
// depends on urlpd_pkg, urlpd_front, urlpd_queue and urlpd_back
//
// Streaming URL unescaper. Escaped text goes in one word per clock through the push/full
// queue interface, decoded text comes out one word per clock through empty/pop. decode_mode
// (written through cfg_we/cfg_wdata while the block is idle) picks %HH only (0), %uHHHH only
// (1, two output words, high byte first) or both (2 or 3, %uHHHH tried first). A '%' that does
// not open a valid escape, or whose escape is cut off by in_last, comes out literally and the
// words after it are scanned again; every other word is copied unchanged. Rate: one input word
// per clock as long as full is low, and one output word per clock from the back end while pop
// is high. The front end resolves each input word in the clock it is accepted and writes at
// most one command into a QUEUE_DEPTH-entry queue; the back end serializes a command at one
// word per clock while pop is high, so a failed escape that flushes n pending words holds the
// back end for n output words, and full rises when the queue fills. With the queue and back
// end empty, the first word of a command passes through the queue and then the back end's
// command register before it shows on out_byte.
`default_nettype none

module url_percent_decoder
    import urlpd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration: decode_mode
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_wdata,
    // input words
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  in_byte,
    input  wire logic        in_last,
    // result words
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       out_byte,
    output logic             out_last
);

    logic [1:0] decode_mode_reg, decode_mode_next;

    logic       accept;
    logic       cmd_valid;
    cmd_t       front_cmd;
    logic       q_full;
    cmd_t       q_cmd;
    logic       q_valid;
    logic       q_pop;

    // mode register; the user must write it only while idle, the block does not enforce this
    always_comb
    begin
        decode_mode_next = cfg_we ? cfg_wdata : decode_mode_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decode_mode_reg <= MODE_HEX;
        end
        else
        begin
            decode_mode_reg <= decode_mode_next;
        end
    end

    // a word is taken whenever push is high and the command queue has room
    assign full   = q_full;
    assign accept = push && !q_full;

    urlpd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .in_byte     (in_byte),
        .in_last     (in_last),
        .decode_mode (decode_mode_reg),
        .cmd_valid   (cmd_valid),
        .cmd         (front_cmd)
    );

    urlpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cmd_valid),
        .wr_cmd   (front_cmd),
        .full     (q_full),
        .rd_en    (q_pop),
        .rd_cmd   (q_cmd),
        .rd_valid (q_valid)
    );

    urlpd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_cmd    (q_cmd),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .pop      (pop),
        .empty    (empty),
        .out_byte (out_byte),
        .out_last (out_last)
    );

endmodule

`default_nettype wire
